// File: rtl/core/qphs_pkg.sv
// Shared constants, codes and interface types of the quadratic probing hash set.
package qphs_pkg;

   // Table geometry
   localparam int CAPACITY = 1024;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int CNT_W    = SLOT_W + 1;

   // Field widths
   localparam int KEY_W    = 31;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int SIZE_W   = 11;

   // Table size register
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1021);
   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);

   // Remainder unit: dividend padded to whole nibbles, four bits per cycle
   localparam int DIV_STEPS  = 4;
   localparam int DVD_W      = 32;
   localparam int DIV_CYCLES = DVD_W / DIV_STEPS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   // Commands
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PROBE_LIMIT = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FOUND       = 3'd5;
   localparam logic [STATUS_W-1:0] ST_SEARCH_MISS = 3'd6;

   // Register indexes
   localparam logic REG_TABLE_SIZE = 1'b0;

   // Remainder unit request and response
   typedef struct packed {
      logic              start;
      logic [KEY_W-1:0]  dividend;
      logic [CNT_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [SLOT_W-1:0] remainder;
   } div_rsp_type;

endpackage

// File: rtl/core/qphs_rem_unit.sv
// Iterative key modulo table size, four restoring steps per cycle.
module qphs_rem_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  qphs_pkg::div_req_type div_req,
   output qphs_pkg::div_rsp_type div_rsp
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [qphs_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [qphs_pkg::DVD_W-1:0]         dvd_ff, dvd_in;
   logic [qphs_pkg::SLOT_W-1:0]        rem_ff, rem_in;
   logic [qphs_pkg::CNT_W-1:0]         dsr_ff, dsr_in;
   logic [qphs_pkg::SLOT_W-1:0]        rem_step;

   // Four dependent compare-subtract steps on the partial remainder
   always_comb begin
      logic [qphs_pkg::CNT_W-1:0] t;
      rem_step = rem_ff;
      for (int k = 0; k < qphs_pkg::DIV_STEPS; k++) begin
         t = {rem_step, dvd_ff[qphs_pkg::DVD_W-1-k]};
         if (t >= dsr_ff) begin
            t = t - dsr_ff;
         end
         rem_step = t[qphs_pkg::SLOT_W-1:0];
      end
   end

   // Sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = {{(qphs_pkg::DVD_W - qphs_pkg::KEY_W){1'b0}}, div_req.dividend};
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = rem_step;
         dvd_in = dvd_ff << qphs_pkg::DIV_STEPS;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == qphs_pkg::DIV_CNT_W'(qphs_pkg::DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// File: rtl/core/quadratic_probe_hash_set_top.sv
// Top level of the quadratic probing hash set: control, slot memory, output and register port.
//
//  channel  | direction | accept condition                 | content
//  ---------+-----------+----------------------------------+------------------------------
//  req_*    | in        | req_tvalid & req_tready          | cmd, key
//  rsp_*    | out       | rsp_tvalid & rsp_tready          | status, position, element_count
//  csr_*    | in/out    | psel & penable & pwrite & pready | table_size at address 0
//
// An operation first computes the home slot in the remainder unit, then issues the first slot
// read, then reads one slot per probe from the slot memory, which has one read and one write port.
// After reset a clearing pass writes every one of the 1024 slots empty, with req_tready low. A
// held result does not block acceptance; a finished operation waits in its last probe until
// the output register is free.
module quadratic_probe_hash_set_top (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [1:0] cmd, [32:2] key, [39:33] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // rsp_tdata: [2:0] status, [12:3] position, [23:13] element_count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_PROBE = 4'b1000
   } state_type;

   localparam int WORD_W = qphs_pkg::KEY_W + 1;

   state_type                           state_ff, state_in;
   logic [qphs_pkg::SIZE_W-1:0]         size_ff, size_in;
   logic [qphs_pkg::CNT_W-1:0]          s_act;
   logic [qphs_pkg::SLOT_W-1:0]         clr_ff, clr_in;
   logic [qphs_pkg::CMD_W-1:0]          cmd_ff, cmd_in;
   logic [qphs_pkg::KEY_W-1:0]          key_ff, key_in;
   logic [qphs_pkg::SLOT_W-1:0]         cur_p_ff, cur_p_in;
   logic [qphs_pkg::SLOT_W-1:0]         step_ff, step_in;
   logic [qphs_pkg::SLOT_W-1:0]         idx_ff, idx_in;
   logic [qphs_pkg::CNT_W-1:0]          occ_ff, occ_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [qphs_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [qphs_pkg::SLOT_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic [qphs_pkg::CNT_W-1:0]          rsp_count_ff, rsp_count_in;

   // Slot memory: bit KEY_W is the occupied flag, the rest the key
   logic [WORD_W-1:0]                   slot_mem [qphs_pkg::CAPACITY];
   logic [WORD_W-1:0]                   mem_q_ff;
   logic [qphs_pkg::SLOT_W-1:0]         mem_raddr;
   logic [qphs_pkg::SLOT_W-1:0]         mem_waddr;
   logic [WORD_W-1:0]                   mem_wdata;
   logic                                mem_we;

   qphs_pkg::div_req_type               div_req;
   qphs_pkg::div_rsp_type               div_rsp;

   logic                                req_fire;
   logic                                out_free;
   logic                                csr_write;
   logic                                slot_used;
   logic                                key_eq;
   logic                                last_probe;
   logic [qphs_pkg::CNT_W-1:0]          p_sum;
   logic [qphs_pkg::CNT_W-1:0]          d_sum;
   logic [qphs_pkg::SLOT_W-1:0]         next_p;
   logic [qphs_pkg::SLOT_W-1:0]         next_step;

   // Size in use, saturated into the legal range
   always_comb begin
      if (size_ff < qphs_pkg::SIZE_MIN) begin
         s_act = qphs_pkg::CNT_W'(qphs_pkg::SIZE_MIN);
      end else if (size_ff > qphs_pkg::SIZE_W'(qphs_pkg::CAPACITY)) begin
         s_act = qphs_pkg::CNT_W'(qphs_pkg::CAPACITY);
      end else begin
         s_act = qphs_pkg::CNT_W'(size_ff);
      end
   end

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      size_in = size_ff;
      if (csr_write && (csr_paddr[2] == qphs_pkg::REG_TABLE_SIZE)) begin
         size_in = csr_pwdata[qphs_pkg::SIZE_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == qphs_pkg::REG_TABLE_SIZE) begin
         csr_prdata = {{(32 - qphs_pkg::SIZE_W){1'b0}}, size_ff};
      end
   end

   // Handshakes
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Home slot from the remainder unit
   assign div_req.start    = req_fire;
   assign div_req.dividend = req_tdata[32:2];
   assign div_req.divisor  = s_act;

   qphs_rem_unit u_rem (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Next probe: slot += 2i+1 and step += 2, both mod size
   always_comb begin
      p_sum = {1'b0, cur_p_ff} + {1'b0, step_ff};
      if (p_sum >= s_act) begin
         p_sum = p_sum - s_act;
      end
      next_p = p_sum[qphs_pkg::SLOT_W-1:0];
      d_sum  = {1'b0, step_ff} + qphs_pkg::CNT_W'(2);
      if (d_sum >= s_act) begin
         d_sum = d_sum - s_act;
      end
      next_step = d_sum[qphs_pkg::SLOT_W-1:0];
   end

   assign slot_used  = mem_q_ff[qphs_pkg::KEY_W];
   assign key_eq     = (mem_q_ff[qphs_pkg::KEY_W-1:0] == key_ff);
   assign last_probe = ({1'b0, idx_ff} == (s_act - 1'b1));

   // Main control
   always_comb begin
      logic                          fin;
      logic [qphs_pkg::STATUS_W-1:0] st;
      logic                          hit_pos;
      fin           = 1'b0;
      st            = qphs_pkg::ST_SEARCH_MISS;
      hit_pos       = 1'b0;
      state_in      = state_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      cur_p_in      = cur_p_ff;
      step_in       = step_ff;
      idx_in        = idx_ff;
      occ_in        = occ_ff;
      mem_raddr     = cur_p_ff;
      mem_we        = 1'b0;
      mem_waddr     = cur_p_ff;
      mem_wdata     = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == qphs_pkg::SLOT_W'(qphs_pkg::CAPACITY - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_tdata[1:0];
               key_in   = req_tdata[32:2];
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               mem_raddr = div_rsp.remainder;
               cur_p_in  = div_rsp.remainder;
               step_in   = qphs_pkg::SLOT_W'(1);
               idx_in    = '0;
               state_in  = ST_PROBE;
            end
         end
         ST_PROBE: begin
            // Decide on the slot just read
            unique case (cmd_ff)
               qphs_pkg::CMD_INSERT: begin
                  if (!slot_used) begin
                     fin = 1'b1; st = qphs_pkg::ST_INSERTED; hit_pos = 1'b1;
                  end else if (key_eq) begin
                     fin = 1'b1; st = qphs_pkg::ST_DUPLICATE;
                  end else if (last_probe) begin
                     fin = 1'b1; st = qphs_pkg::ST_PROBE_LIMIT;
                  end
               end
               qphs_pkg::CMD_REMOVE: begin
                  if (slot_used && key_eq) begin
                     fin = 1'b1; st = qphs_pkg::ST_REMOVED; hit_pos = 1'b1;
                  end else if (!slot_used || last_probe) begin
                     fin = 1'b1; st = qphs_pkg::ST_NOT_FOUND;
                  end
               end
               default: begin
                  // search, and the reserved code acting as search
                  if (slot_used && key_eq) begin
                     fin = 1'b1; st = qphs_pkg::ST_FOUND; hit_pos = 1'b1;
                  end else if (!slot_used || last_probe) begin
                     fin = 1'b1; st = qphs_pkg::ST_SEARCH_MISS;
                  end
               end
            endcase

            if (!fin) begin
               mem_raddr = next_p;
               cur_p_in  = next_p;
               step_in   = next_step;
               idx_in    = idx_ff + 1'b1;
            end else if (out_free) begin
               // Commit: write back the slot on insert or remove, and load the output register
               occ_in = occ_ff;
               if (st == qphs_pkg::ST_INSERTED) begin
                  mem_we    = 1'b1;
                  mem_wdata = {1'b1, key_ff};
                  occ_in    = occ_ff + 1'b1;
               end else if (st == qphs_pkg::ST_REMOVED) begin
                  mem_we    = 1'b1;
                  mem_wdata = '0;
                  if (occ_ff != '0) begin
                     occ_in = occ_ff - 1'b1;
                  end
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = st;
               rsp_pos_in    = hit_pos ? cur_p_ff : '0;
               rsp_count_in  = occ_in;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         size_ff      <= qphs_pkg::SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         size_ff      <= size_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      cur_p_ff      <= cur_p_in;
      step_ff       <= step_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Slot memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= slot_mem[mem_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_pos_ff, rsp_status_ff};

`ifndef SYNTH
   // Probed slot always lies inside the table in use
   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> ({1'b0, cur_p_ff} < s_act))
      else $error("probe slot outside the table");

   // A successful insert reports the count one above the previous one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_tready) &&
       rsp_status_in == qphs_pkg::ST_INSERTED)
      |=> (occ_ff == $past(occ_ff) + 1'b1))
      else $error("insert did not bump the element count");

   // No result and no transaction while the clearing pass runs
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!rsp_valid_ff && occ_ff == '0))
      else $error("activity during the clearing pass");
`endif

endmodule
